[hw/rtl/bfrw_pkg.sv]
// Package for the block flush receive window unit.
// Field widths, action codes and the item/result structs shared by every module except the tag RAM.
// No dependencies.
package bfrw_pkg;

  // Defaults for the top-level parameter
  localparam int WINDOW_DEF = 32;

  // Payload sizes above one slot count as one slot
  localparam int SLOT_BYTES = 1024;

  // Fixed field widths
  localparam int ID_W    = 31;
  localparam int SIZE_W  = 11;
  localparam int CFG_W   = 6;
  localparam int SLOT_W  = 5;
  localparam int BYTES_W = 16;

  // Generation tag width of the slot memory
  localparam int EPOCH_W = 4;

  // Packed stream widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int ACT_W      = 3;

  // Reset value of window_in_use
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  typedef enum logic [ACT_W-1:0] {
    ACT_NEW       = 3'd0,
    ACT_DUP       = 3'd1,
    ACT_DELIVERED = 3'd2,
    ACT_DROP      = 3'd3,
    ACT_FIN       = 3'd4
  } action_t;

  // One packet header
  typedef struct packed {
    logic              is_fin;
    logic [ID_W-1:0]   packet_id;
    logic [SIZE_W-1:0] pay_len;
  } item_t;

  // One decision
  typedef struct packed {
    action_t            action;
    logic               send_ack;
    logic               ack_is_finack;
    logic [ID_W-1:0]    ack_id;
    logic [SLOT_W-1:0]  write_slot;
    logic               write_enable;
    logic               flush;
    logic [BYTES_W-1:0] flush_bytes;
  } result_t;

endpackage

[hw/rtl/bfrw_tag_ram.sv]
// Simple dual-port RAM holding the generation tag of each window slot.
// One write and one registered read per cycle. Uses no package.
module bfrw_tag_ram #(
  parameter int DEPTH  = 32,
  parameter int DATA_W = 4,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/bfrw_window_ctrl.sv]
// Window decision and state update: base, count, byte count, slot valid bits,
// generation counter and forwarding of the last update. Uses bfrw_pkg.
module bfrw_window_ctrl #(
  parameter int WINDOW = bfrw_pkg::WINDOW_DEF,
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bfrw_pkg::CFG_W-1:0]    win_cfg,
  input  logic [bfrw_pkg::ID_W-1:0]     in_id,
  output logic [IDX_W-1:0]              rd_addr,
  input  logic [bfrw_pkg::EPOCH_W-1:0]  rd_tag,
  input  bfrw_pkg::item_t               item,
  input  logic                          fire,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [bfrw_pkg::EPOCH_W-1:0]  wr_data,
  output bfrw_pkg::result_t             result
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int WW    = (CNT_W > bfrw_pkg::CFG_W) ? CNT_W : bfrw_pkg::CFG_W;
  localparam int ID_W  = bfrw_pkg::ID_W;
  localparam int EW    = bfrw_pkg::EPOCH_W;
  localparam int BW    = bfrw_pkg::BYTES_W;
  localparam int SW    = bfrw_pkg::SIZE_W;

  // state
  logic [ID_W-1:0]  base_r, base_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [BW-1:0]    bytes_r, bytes_nxt;
  logic [EW-1:0]    epoch_r, epoch_nxt;
  logic [WINDOW-1:0] valid_r, valid_nxt;
  // last update, for reads issued before it was written
  logic             last_clr_r, last_wr_r;
  logic [IDX_W-1:0] last_slot_r;

  logic [WW-1:0]     cfg_ext, w_eff;
  logic [ID_W:0]     w_ext, id_ext, base_plus_w, adv_plus_w;
  logic [ID_W-1:0]   adv_base, eff_base;
  logic              beyond, full, beyond2, flush_adv, dropped, in_win, clr;
  logic [IDX_W-1:0]  idx;
  logic              mask_bit, is_new;
  logic [SW-1:0]     size_c;
  logic [BW+1:0]     bytes_sum;
  logic [BW-1:0]     bytes_base;
  logic [CNT_W-1:0]  count_base;
  logic [BW-1:0]     fbytes;

  // read address for the next item, relative to the current base
  assign rd_addr = IDX_W'(in_id[IDX_W-1:0] - base_r[IDX_W-1:0] - IDX_W'(1));

  // effective window: zero counts as one, clamp at WINDOW
  always_comb begin
    cfg_ext = WW'(win_cfg);
    if (cfg_ext == '0) begin
      w_eff = WW'(1);
    end else if (cfg_ext > WW'(WINDOW)) begin
      w_eff = WW'(WINDOW);
    end else begin
      w_eff = cfg_ext;
    end
  end

  // window tests, compared on full values with no wrap
  always_comb begin
    w_ext       = (ID_W+1)'(w_eff);
    id_ext      = {1'b0, item.packet_id};
    base_plus_w = {1'b0, base_r} + w_ext;
    beyond      = id_ext > base_plus_w;
    full        = WW'(count_r) >= w_eff;
    adv_base    = base_plus_w[ID_W-1:0];
    adv_plus_w  = {1'b0, adv_base} + w_ext;
    beyond2     = id_ext > adv_plus_w;
    flush_adv   = !item.is_fin && beyond && full;
    dropped     = !item.is_fin && beyond && (!full || beyond2);
    eff_base    = flush_adv ? adv_base : base_r;
    in_win      = item.packet_id > eff_base;
    // an in-window id always lands below the effective window
    idx         = IDX_W'(item.packet_id[IDX_W-1:0] - eff_base[IDX_W-1:0] - IDX_W'(1));
    clr         = item.is_fin || flush_adv;
  end

  // mask bit of the slot: own flush, then last write, then last clear, then memory
  always_comb begin
    priority if (flush_adv) begin
      mask_bit = 1'b0;
    end else if (last_wr_r && (last_slot_r == idx)) begin
      mask_bit = 1'b1;
    end else if (last_clr_r) begin
      mask_bit = 1'b0;
    end else begin
      mask_bit = (32'(idx) < WINDOW) && valid_r[idx] && (rd_tag == epoch_r);
    end
    is_new = !item.is_fin && !dropped && in_win && !mask_bit;
  end

  // result
  always_comb begin
    fbytes = (item.is_fin || flush_adv) ? bytes_r : '0;
    result = '0;
    result.flush       = clr;
    result.flush_bytes = fbytes;
    priority if (item.is_fin) begin
      result.action        = bfrw_pkg::ACT_FIN;
      result.send_ack      = 1'b1;
      result.ack_is_finack = 1'b1;
    end else if (dropped) begin
      result.action = bfrw_pkg::ACT_DROP;
    end else if (in_win) begin
      result.action       = is_new ? bfrw_pkg::ACT_NEW : bfrw_pkg::ACT_DUP;
      result.send_ack     = 1'b1;
      result.ack_id       = item.packet_id;
      result.write_enable = is_new;
      result.write_slot   = is_new ? bfrw_pkg::SLOT_W'(idx) : '0;
    end else begin
      result.action   = bfrw_pkg::ACT_DELIVERED;
      result.send_ack = 1'b1;
      result.ack_id   = item.packet_id;
    end
  end

  // next state
  always_comb begin
    size_c     = (item.pay_len > SW'(bfrw_pkg::SLOT_BYTES)) ?
                 SW'(bfrw_pkg::SLOT_BYTES) : item.pay_len;
    bytes_base = clr ? '0 : bytes_r;
    count_base = clr ? '0 : count_r;
    bytes_sum  = (BW+2)'(bytes_base) + (BW+2)'(size_c);
    base_nxt   = item.is_fin ? '0 : eff_base;
    count_nxt  = count_base;
    bytes_nxt  = bytes_base;
    epoch_nxt  = clr ? EW'(epoch_r + EW'(1)) : epoch_r;
    valid_nxt  = (clr && (epoch_r == '1)) ? '0 : valid_r;
    if (is_new) begin
      count_nxt = CNT_W'(count_base + CNT_W'(1));
      bytes_nxt = (bytes_sum > (BW+2)'({BW{1'b1}})) ? '1 : BW'(bytes_sum);
      if (32'(idx) < WINDOW) begin
        valid_nxt[idx] = 1'b1;
      end
    end
  end

  // tag write for a newly received slot
  assign wr_en   = fire && is_new;
  assign wr_addr = idx;
  assign wr_data = epoch_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      count_r     <= '0;
      bytes_r     <= '0;
      epoch_r     <= '0;
      valid_r     <= '0;
      last_clr_r  <= 1'b0;
      last_wr_r   <= 1'b0;
      last_slot_r <= '0;
    end else if (fire) begin
      base_r      <= base_nxt;
      count_r     <= count_nxt;
      bytes_r     <= bytes_nxt;
      epoch_r     <= epoch_nxt;
      valid_r     <= valid_nxt;
      last_clr_r  <= clr;
      last_wr_r   <= is_new;
      last_slot_r <= idx;
    end
  end

endmodule

[hw/rtl/block_flush_receive_window_unit.sv]
// Top level of the block flush receive window unit: input stage, slot tag
// RAM, window control and output register. Uses bfrw_pkg, bfrw_tag_ram and
// bfrw_window_ctrl.
//
//  Channel | Direction | tdata (low bit up)              | tuser
//  --------+-----------+---------------------------------+--------------
//  in_     | slave     | packet_id, pay_len               | is_fin
//  out_    | master    | send_ack, ack_is_finack, ack_id, | action
//          |           | write_slot, write_enable, flush, |
//          |           | flush_bytes                      |
//  cfg_    | write     | window_in_use                    | -
//
// One request per cycle while the output does not stall; an accepted header is held
// in the decision stage register, and its decision is loaded into the output
// register, from which its result is taken.
// The slot check reads the tag RAM at acceptance; the update of the previous
// request is forwarded into the decision, so no bubble is needed.
// Synchronous active-low reset: empty pipeline, base and counts zero,
// window_in_use 32. No clearing pass; slot validity resets at once.
// A stalled output holds the decision stage; input stalls only when both are full.
module block_flush_receive_window_unit #(
  parameter int WINDOW = bfrw_pkg::WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bfrw_pkg::IN_DATA_W-1:0]    in_tdata,   // packet_id, pay_len
  input  logic                              in_tuser,   // is_fin
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bfrw_pkg::OUT_DATA_W-1:0]   out_tdata,  // send_ack, ack_is_finack,
                                                        // ack_id, write_slot,
                                                        // write_enable, flush,
                                                        // flush_bytes
  output logic [bfrw_pkg::ACT_W-1:0]        out_tuser,  // action
  input  logic                              cfg_we,
  input  logic [bfrw_pkg::CFG_W-1:0]        cfg_wdata   // window_in_use
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int ID_W  = bfrw_pkg::ID_W;
  localparam int SW    = bfrw_pkg::SIZE_W;

  logic [bfrw_pkg::CFG_W-1:0]   win_cfg_r;
  logic                         s1_v_r, s1_v_nxt;
  bfrw_pkg::item_t              s1_item_r;
  logic                         out_v_r, out_v_nxt;
  bfrw_pkg::result_t            out_res_r;
  bfrw_pkg::result_t            result;
  logic                         in_fire, s1_fire;
  logic [IDX_W-1:0]             rd_addr, wr_addr;
  logic [bfrw_pkg::EPOCH_W-1:0] rd_tag, wr_data;
  logic                         wr_en;
  bfrw_pkg::item_t              in_item;

  // handshake
  assign s1_fire   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // unpack input request
  always_comb begin
    in_item.is_fin    = in_tuser;
    in_item.packet_id = in_tdata[ID_W-1:0];
    in_item.pay_len   = in_tdata[ID_W+SW-1:ID_W];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cfg_r <= bfrw_pkg::CFG_RESET;
    end else if (cfg_we) begin
      win_cfg_r <= cfg_wdata;
    end
  end

  // decision stage
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_fire) begin
      s1_v_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
  end

  // output register
  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_fire) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= result;
    end
  end

  bfrw_tag_ram #(
    .DEPTH  (WINDOW),
    .DATA_W (bfrw_pkg::EPOCH_W)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_tag)
  );

  bfrw_window_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .win_cfg (win_cfg_r),
    .in_id   (in_item.packet_id),
    .rd_addr (rd_addr),
    .rd_tag  (rd_tag),
    .item    (s1_item_r),
    .fire    (s1_fire),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .result  (result)
  );

  // pack output request
  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.action;
  assign out_tdata  = {out_res_r.flush_bytes,
                       out_res_r.flush,
                       out_res_r.write_enable,
                       out_res_r.write_slot,
                       out_res_r.ack_id,
                       out_res_r.ack_is_finack,
                       out_res_r.send_ack};

endmodule

[hw/rtl/bfrw_checker.sv]
// Port-level checks for block_flush_receive_window_unit, with the bind that
// attaches them. Uses bfrw_pkg.
module bfrw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bfrw_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [bfrw_pkg::ACT_W-1:0]      out_tuser
);

  // stalled output request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output request changed while stalled");

  // input backpressure only when the output side is full and stalled
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // fin answers with a finack, a flush and ack id zero
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == bfrw_pkg::ACT_FIN) |->
      out_tdata[0] && out_tdata[1] && out_tdata[39] && (out_tdata[32:2] == '0))
    else $error("fin result malformed");

  // dropped packet gets no ack and no payload write
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == bfrw_pkg::ACT_DROP) |-> !out_tdata[0] && !out_tdata[38])
    else $error("dropped packet acknowledged or stored");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

endmodule

bind block_flush_receive_window_unit bfrw_checker u_bfrw_checker (.*);

[bench/testbench.sv]
// Testbench for block_flush_receive_window_unit: directed and random packet headers
// against a built-in window predictor, with random idling and output back-pressure.
// Depends on bfrw_pkg and the RTL of block_flush_receive_window_unit.
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_HALF   = 10;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 300;

  localparam int ID_W       = bfrw_pkg::ID_W;
  localparam int SIZE_W     = bfrw_pkg::SIZE_W;
  localparam int CFG_W      = bfrw_pkg::CFG_W;
  localparam int SLOT_W     = bfrw_pkg::SLOT_W;
  localparam int BYTES_W    = bfrw_pkg::BYTES_W;
  localparam int IN_DATA_W  = bfrw_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = bfrw_pkg::OUT_DATA_W;
  localparam int ACT_W      = bfrw_pkg::ACT_W;
  localparam int WINDOW_DEF = bfrw_pkg::WINDOW_DEF;
  localparam int SLOT_BYTES = bfrw_pkg::SLOT_BYTES;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [ACT_W-1:0]      out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  // Predicted window state
  logic [ID_W-1:0]       win_base;
  logic [WINDOW_DEF-1:0] win_mask;
  int unsigned           win_count;
  int unsigned           win_bytes;
  logic [CFG_W-1:0]      win_cfg;

  bfrw_pkg::result_t decision_q[$];
  int          err_count   = 0;
  int          send_idle   = 0;
  int          recv_stall  = 0;
  int          hold_cycles = 0;
  int          quiet_count = 0;

  block_flush_receive_window_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Effective window: 0 means 1, above the slot count means the slot count
  function automatic int unsigned eff_window();
    int unsigned w;
    w = 32'(win_cfg);
    if (w == 0) w = 1;
    if (w > WINDOW_DEF) w = WINDOW_DEF;
    return w;
  endfunction

  function automatic void clear_window();
    win_mask  = '0;
    win_count = 0;
    win_bytes = 0;
  endfunction

  // Decision for one accepted header; updates the predicted window state
  function automatic bfrw_pkg::result_t window_decide(input bfrw_pkg::item_t it);
    bfrw_pkg::result_t r;
    int unsigned w;
    int unsigned sz;
    int unsigned idx;
    logic        dropped;
    logic [32:0] top;
    logic [32:0] id;
    r       = '0;
    r.action = bfrw_pkg::ACT_NEW;
    w       = eff_window();
    sz      = (it.pay_len > SLOT_BYTES) ? 32'(SLOT_BYTES) : 32'(it.pay_len);
    id      = {2'b00, it.packet_id};
    if (it.is_fin) begin
      r.action        = bfrw_pkg::ACT_FIN;
      r.send_ack      = 1'b1;
      r.ack_is_finack = 1'b1;
      r.flush         = 1'b1;
      r.flush_bytes   = win_bytes[BYTES_W-1:0];
      win_base        = '0;
      clear_window();
    end else begin
      dropped = 1'b0;
      top     = {2'b00, win_base} + 33'(w);
      if (id > top) begin
        if (win_count >= w) begin
          // full window: write it out and move the base on
          r.flush       = 1'b1;
          r.flush_bytes = win_bytes[BYTES_W-1:0];
          clear_window();
          win_base = win_base + w[ID_W-1:0];
          top      = {2'b00, win_base} + 33'(w);
          if (id > top) dropped = 1'b1;
        end else begin
          dropped = 1'b1;
        end
      end
      if (dropped) begin
        r.action = bfrw_pkg::ACT_DROP;
      end else if (it.packet_id > win_base) begin
        idx = 32'(it.packet_id - win_base) - 1;
        if (idx >= WINDOW_DEF) idx = WINDOW_DEF - 1;
        if (!win_mask[idx]) begin
          win_mask[idx] = 1'b1;
          win_count++;
          win_bytes += sz;
          if (win_bytes > 65535) win_bytes = 65535;
          r.action       = bfrw_pkg::ACT_NEW;
          r.write_slot   = idx[SLOT_W-1:0];
          r.write_enable = 1'b1;
        end else begin
          r.action = bfrw_pkg::ACT_DUP;
        end
        r.send_ack = 1'b1;
        r.ack_id   = it.packet_id;
      end else begin
        r.action   = bfrw_pkg::ACT_DELIVERED;
        r.send_ack = 1'b1;
        r.ack_id   = it.packet_id;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Offer one request; predict it once accepted
  task automatic send_header(input logic fin, input logic [ID_W-1:0] id,
                             input logic [SIZE_W-1:0] size);
    bfrw_pkg::item_t it;
    it.is_fin    = fin;
    it.packet_id = id;
    it.pay_len   = size;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-ID_W-SIZE_W){1'b0}}, size, id};
    in_tuser  <= fin;
    do @(posedge clk); while (!in_tready);
    decision_q.push_back(window_decide(it));
  endtask

  // Drop valid and wait until every decision is back
  task automatic wait_window_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] value);
    wait_window_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    win_cfg = value;
  endtask

  // Header aimed at the current window state, with some noise
  task automatic send_random_header();
    int unsigned w;
    int unsigned r;
    int unsigned idx;
    int unsigned k;
    int unsigned back;
    logic        found;
    logic        fin;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
    w    = eff_window();
    r    = $urandom_range(0, 99);
    fin  = 1'b0;
    id   = ID_W'($urandom);
    size = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(1025, 2047)) :
                                         SIZE_W'($urandom_range(0, 1024));
    if (r < 3) begin
      fin = 1'b1;
    end else if (r < 8) begin
      // noise: any id
    end else if (r < 15) begin
      back = $urandom_range(0, 3);
      id   = (win_base >= back) ? ID_W'(win_base - back) : '0;
    end else if (r < 25) begin
      id = ID_W'(win_base + w + 1 + $urandom_range(0, 2 * w));
    end else begin
      idx   = $urandom_range(0, w - 1);
      found = 1'b0;
      if ($urandom_range(0, 3) != 0) begin
        for (k = 0; k < w; k++) begin
          if (!found && !win_mask[(idx + k) % w]) begin
            idx   = (idx + k) % w;
            found = 1'b1;
          end
        end
      end
      id = ID_W'(win_base + 1 + idx);
    end
    send_header(fin, id, size);
  endtask

  // Field extremes, every action, oversized payloads, window edge cases
  task automatic test_directed_edges();
    send_header(1'b0, 31'd0, 11'd0);           // at base: delivered
    send_header(1'b0, 31'd1, 11'd0);           // new in slot 0
    send_header(1'b0, 31'd1, 11'd5);           // duplicate
    send_header(1'b0, 31'd32, 11'd2047);       // oversized, last slot
    send_header(1'b0, 31'd33, 11'd100);        // beyond, not full: drop
    send_header(1'b0, 31'h7FFF_FFFF, 11'd1024); // max id: drop
    send_header(1'b1, 31'h7FFF_FFFF, 11'd2047); // fin flushes bytes
    // zero window counts as one slot
    write_window(6'd0);
    send_header(1'b0, 31'd1, 11'd1024);
    send_header(1'b0, 31'd2, 11'd1);           // full: flush then new
    send_header(1'b0, 31'd5, 11'd7);           // still beyond after advance
    send_header(1'b0, 31'd2, 11'd0);           // already delivered
    send_header(1'b0, 31'd3, 11'd1023);
    send_header(1'b1, 31'd0, 11'd0);
    // window above the slot count is clamped
    write_window(6'd63);
    send_header(1'b0, 31'd32, 11'd512);
    send_header(1'b0, 31'd33, 11'd512);        // not full: drop
    send_header(1'b1, 31'd12345, 11'd0);
    write_window(6'd32);
  endtask

  // Lowering the window while slots are filled makes it count as full
  task automatic test_lowered_window();
    int i;
    write_window(6'd32);
    for (i = 1; i <= 10; i++) send_header(1'b0, i[ID_W-1:0], 11'd1000);
    write_window(6'd4);
    send_header(1'b0, 31'd5, 11'd10);          // flush 10 slots, base 4, new
    send_header(1'b0, 31'd9, 11'd10);          // beyond, count 1: drop
    send_header(1'b1, 31'd0, 11'd0);
  endtask

  task automatic test_random_phase(input int n, input int idle, input int stall,
                                   input logic [CFG_W-1:0] window);
    int i;
    write_window(window);
    send_idle  = idle;
    recv_stall = stall;
    for (i = 0; i < n; i++) send_random_header();
    wait_window_idle();
    send_idle  = 0;
    recv_stall = 0;
  endtask

  // Receiver holds off while headers keep coming, so the input stalls
  task automatic test_backpressure();
    int i;
    write_window(6'd8);
    send_idle   = 0;
    recv_stall  = 0;
    hold_cycles = HOLD_LEN;
    for (i = 0; i < 30; i++) send_random_header();
    wait_window_idle();
  endtask

  // Receiver ready, with random stalls and an optional long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin
    bfrw_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decision_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        want = decision_q.pop_front();
        if (out_tuser != want.action)
          report_mismatch("action", out_tuser, want.action);
        if (out_tdata[0] != want.send_ack)
          report_mismatch("send_ack", out_tdata[0], want.send_ack);
        if (out_tdata[1] != want.ack_is_finack)
          report_mismatch("ack_is_finack", out_tdata[1], want.ack_is_finack);
        if (out_tdata[32:2] != want.ack_id)
          report_mismatch("ack_id", out_tdata[32:2], want.ack_id);
        if (out_tdata[37:33] != want.write_slot)
          report_mismatch("write_slot", out_tdata[37:33], want.write_slot);
        if (out_tdata[38] != want.write_enable)
          report_mismatch("write_enable", out_tdata[38], want.write_enable);
        if (out_tdata[39] != want.flush)
          report_mismatch("flush", out_tdata[39], want.flush);
        if (out_tdata[55:40] != want.flush_bytes)
          report_mismatch("flush_bytes", out_tdata[55:40], want.flush_bytes);
      end
    end
  end

  // Watchdog: too long without any request moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Test sequence
  initial begin
    win_base = '0;
    win_cfg  = bfrw_pkg::CFG_RESET;
    clear_window();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_lowered_window();
    test_random_phase(250, 0, 0, 6'd32);
    test_random_phase(250, 64, 0, 6'd5);
    test_random_phase(250, 0, 64, 6'd1);
    test_random_phase(250, 28, 28, CFG_W'($urandom_range(0, 63)));
    test_backpressure();

    wait_window_idle();
    repeat (5) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
